>>> rtl/sts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// shared types and codes of the timer slot scheduler
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int TIMER_SLOTS_DEF = 16;
	localparam int TICK_BITS_DEF   = 32;
	localparam int MAX_FIRE        = 16;
	localparam int FIRE_W          = $clog2(MAX_FIRE + 1);

	localparam logic [1:0] FUNC_SETUP   = 2'd0;
	localparam logic [1:0] FUNC_ENABLE  = 2'd1;
	localparam logic [1:0] FUNC_DISABLE = 2'd2;
	localparam logic [1:0] FUNC_TICK    = 2'd3;

	localparam logic [1:0] KIND_ONESHOT  = 2'd0;
	localparam logic [1:0] KIND_COUNTED  = 2'd1;
	localparam logic [1:0] KIND_PERIODIC = 2'd2;

	localparam logic [1:0] RES_REPLY = 2'd0;
	localparam logic [1:0] RES_FIRED = 2'd1;
	localparam logic [1:0] RES_IDLE  = 2'd2;

	// queued item, classified by the front end
	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  slot_index;
		logic [1:0]  timer_kind;
		logic [31:0] period_ticks;
		logic [15:0] repeat_count;
		logic        slot_ok;
	} sts_item_t;

	// queue to back end handshake
	typedef struct packed {
		logic avail;
		logic pop;
	} sts_qctl_t;

endpackage

>>> rtl/sts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_front
// accepts items, checks the slot index and queues them for the back end
// ----------------------------------------------------------------------------
module sts_front #(
	parameter int TIMER_SLOTS = sts_pkg::TIMER_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [3:0]           slot_index,
	input  logic [1:0]           timer_kind,
	input  logic [31:0]          period_ticks,
	input  logic [15:0]          repeat_count,
	output sts_pkg::sts_item_t   q_item,
	input  logic                 q_pop,
	output logic                 q_avail
);
	import sts_pkg::*;

	sts_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	sts_item_t  new_item;

	always_comb begin
		new_item.func         = func;
		new_item.slot_index   = slot_index;
		new_item.timer_kind   = timer_kind;
		new_item.period_ticks = period_ticks;
		new_item.repeat_count = repeat_count;
		new_item.slot_ok      = (9'(slot_index) < 9'(TIMER_SLOTS));
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_avail  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_avail;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> rtl/sts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_back
// slot state, tick counter, due scan and result register
// ----------------------------------------------------------------------------
module sts_back #(
	parameter int TIMER_SLOTS = sts_pkg::TIMER_SLOTS_DEF,
	parameter int TICK_BITS   = sts_pkg::TICK_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sts_pkg::sts_item_t q_item,
	input  sts_pkg::sts_qctl_t q_ctl_in,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic [3:0]         fired_slot,
	output logic               status,
	output logic               last_of_run
);
	import sts_pkg::*;

	localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int IW     = (SLOT_W > 4) ? SLOT_W : 4;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t                 state_q;
	logic [TICK_BITS-1:0]   now_q;
	logic [TICK_BITS-1:0]   wake_q   [TIMER_SLOTS];
	logic [31:0]            period_q [TIMER_SLOTS];
	logic [15:0]            rem_q    [TIMER_SLOTS];
	logic [1:0]             kind_q   [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] armed_q;
	logic [TIMER_SLOTS-1:0] done_q;
	logic [SLOT_W-1:0]      idx_q;
	logic                   best_v_q;
	logic [SLOT_W-1:0]      best_q;
	logic [TICK_BITS-1:0]   best_age_q;
	logic                   pend_v_q;
	logic [SLOT_W-1:0]      pend_q;
	logic [FIRE_W-1:0]      fire_cnt_q;

	logic                   out_free;
	logic                   out_load;
	logic [IW-1:0]          cmd_ext;
	logic [SLOT_W-1:0]      cmd_s;
	logic [TICK_BITS-1:0]   age;
	logic                   cur_due;
	logic                   better;
	logic                   sel_v;
	logic [SLOT_W-1:0]      sel;
	logic                   last_idx;
	logic                   fire_go;
	logic                   is_cmd;
	logic [IW-1:0]          pend_ext;

	assign out_free = !out_valid || !out_stall;
	assign cmd_ext  = IW'(q_item.slot_index);
	assign cmd_s    = cmd_ext[SLOT_W-1:0];
	assign age      = now_q - wake_q[idx_q];
	assign cur_due  = armed_q[idx_q] && !done_q[idx_q] && !age[TICK_BITS-1];
	assign better   = cur_due && (!best_v_q || (age > best_age_q));
	assign sel_v    = best_v_q || better;
	assign sel      = better ? idx_q : best_q;
	assign last_idx = (idx_q == SLOT_W'(TIMER_SLOTS - 1));
	assign fire_go  = (state_q == ST_SCAN) && last_idx && sel_v && (!pend_v_q || out_free);
	assign is_cmd   = (q_item.func != FUNC_TICK);
	assign q_pop    = (state_q == ST_IDLE) && q_ctl_in.avail && (!is_cmd || out_free);
	assign pend_ext = IW'(pend_q);
	// a new result is loaded into the output register this cycle
	assign out_load = (q_pop && is_cmd) || (fire_go && pend_v_q) ||
		((state_q == ST_OUT) && out_free);

	// wake times carry no reset
	always_ff @(posedge clk) begin
		if (q_pop && q_item.func == FUNC_ENABLE && q_item.slot_ok) begin
			wake_q[cmd_s] <= now_q + TICK_BITS'(period_q[cmd_s]);
		end else if (fire_go) begin
			wake_q[sel] <= wake_q[sel] + TICK_BITS'(period_q[sel]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			armed_q     <= '0;
			done_q      <= '0;
			idx_q       <= '0;
			best_v_q    <= 1'b0;
			best_q      <= '0;
			best_age_q  <= '0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			fire_cnt_q  <= '0;
			out_valid   <= 1'b0;
			result_kind <= RES_REPLY;
			fired_slot  <= '0;
			status      <= 1'b0;
			last_of_run <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				period_q[i] <= 32'd1;
				rem_q[i]    <= 16'd1;
				kind_q[i]   <= KIND_ONESHOT;
			end
		end else begin
			if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (is_cmd) begin
							out_valid   <= 1'b1;
							result_kind <= RES_REPLY;
							fired_slot  <= q_item.slot_index;
							status      <= 1'b0;
							last_of_run <= 1'b1;
							priority case (q_item.func)
								FUNC_SETUP: begin
									if (q_item.slot_ok) begin
										kind_q[cmd_s]   <= q_item.timer_kind;
										period_q[cmd_s] <= q_item.period_ticks;
										rem_q[cmd_s]    <= q_item.repeat_count;
									end
								end
								FUNC_ENABLE: begin
									if (q_item.slot_ok) armed_q[cmd_s] <= 1'b1;
								end
								default: begin
									if (q_item.slot_ok && armed_q[cmd_s]) begin
										armed_q[cmd_s] <= 1'b0;
									end else begin
										status <= 1'b1;
									end
								end
							endcase
						end else begin
							now_q      <= now_q + 1'b1;
							done_q     <= '0;
							fire_cnt_q <= '0;
							pend_v_q   <= 1'b0;
							idx_q      <= '0;
							best_v_q   <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (!last_idx) begin
						idx_q <= idx_q + 1'b1;
						if (better) begin
							best_v_q   <= 1'b1;
							best_q     <= idx_q;
							best_age_q <= age;
						end
					end else if (!sel_v) begin
						state_q <= ST_OUT;
					end else if (fire_go) begin
						if (pend_v_q) begin
							out_valid   <= 1'b1;
							result_kind <= RES_FIRED;
							fired_slot  <= pend_ext[3:0];
							status      <= 1'b0;
							last_of_run <= 1'b0;
						end
						pend_v_q    <= 1'b1;
						pend_q      <= sel;
						done_q[sel] <= 1'b1;
						fire_cnt_q  <= fire_cnt_q + 1'b1;
						idx_q       <= '0;
						best_v_q    <= 1'b0;
						priority case (kind_q[sel])
							KIND_COUNTED: begin
								if (rem_q[sel] <= 16'd1) begin
									rem_q[sel]   <= '0;
									armed_q[sel] <= 1'b0;
								end else begin
									rem_q[sel] <= rem_q[sel] - 1'b1;
								end
							end
							KIND_PERIODIC: ;
							default: armed_q[sel] <= 1'b0;
						endcase
						if (fire_cnt_q == FIRE_W'(MAX_FIRE - 1)) state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						result_kind <= pend_v_q ? RES_FIRED : RES_IDLE;
						fired_slot  <= pend_v_q ? pend_ext[3:0] : 4'd0;
						status      <= 1'b0;
						last_of_run <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/software_timer_scheduler_top.sv
`timescale 1ns / 1ps
// a command reply is loaded into the result register when the back end pops its item
// a tick scans all slots once for each slot that fires, plus a closing empty scan
// a burst of MAX_FIRE slots skips the closing empty scan
// the due scan, one slot a cycle, sets the tick time
// a two-entry queue takes items while the back end works
// arst_n clears tick counter, slot setup, armed bits, queue and result register
// ----------------------------------------------------------------------------
// software_timer_scheduler_top
// timer slot scheduler with a wrap-aware wake time order
// ----------------------------------------------------------------------------
module software_timer_scheduler_top #(
	parameter int TIMER_SLOTS = sts_pkg::TIMER_SLOTS_DEF,
	parameter int TICK_BITS   = sts_pkg::TICK_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  slot_index,
	input  logic [1:0]  timer_kind,
	input  logic [31:0] period_ticks,
	input  logic [15:0] repeat_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [3:0]  fired_slot,
	output logic        status,
	output logic        last_of_run
);
	import sts_pkg::*;

	sts_item_t q_item;
	sts_qctl_t q_ctl;
	logic      q_pop;
	logic      q_avail;

	// front end: accept and classify items
	sts_front #(.TIMER_SLOTS(TIMER_SLOTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.slot_index   (slot_index),
		.timer_kind   (timer_kind),
		.period_ticks (period_ticks),
		.repeat_count (repeat_count),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.q_avail      (q_avail)
	);

	always_comb begin
		q_ctl.avail = q_avail;
		q_ctl.pop   = q_pop;
	end

	// back end: slot state, scan for due slots, result register
	sts_back #(.TIMER_SLOTS(TIMER_SLOTS), .TICK_BITS(TICK_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_item      (q_item),
		.q_ctl_in    (q_ctl),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.fired_slot  (fired_slot),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

>>> rtl/sts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker
// port level checks of the timer slot scheduler
// ----------------------------------------------------------------------------
module sts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] result_kind,
	input logic [3:0] fired_slot,
	input logic       status,
	input logic       last_of_run
);
	import sts_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(fired_slot))
		else $error("stalled result changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_kind == RES_REPLY || result_kind == RES_FIRED ||
			result_kind == RES_IDLE))
		else $error("bad result kind");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result_kind == RES_REPLY)
		else $error("status on non reply");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_IDLE |-> last_of_run && fired_slot == 4'd0)
		else $error("bad idle tick result");

endmodule

bind software_timer_scheduler_top sts_checker u_sts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.fired_slot  (fired_slot),
	.status      (status),
	.last_of_run (last_of_run)
);
